// ===== rtl/edge_length_octilinearity_criterion_top_defines.svh =====
// assertion macros for the edge length and octilinearity criterion block
`ifndef EDGE_LENGTH_OCTILINEARITY_CRITERION_TOP_DEFINES_SVH
`define EDGE_LENGTH_OCTILINEARITY_CRITERION_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition now implies property in the same cycle
`define ELO_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// condition now implies property in the next cycle
`define ELO_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define ELO_ASSERT_NOW(label, cond, prop, msg)
`define ELO_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// ===== rtl/elo_pkg.sv =====
// shared types and constants of the edge criterion block
package elo_pkg;

  // sequencer states, one-hot
  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_ABS  = 21'h000002,
    S_SQA  = 21'h000004,
    S_SQB  = 21'h000008,
    S_ROOT = 21'h000010,
    S_NORM = 21'h000020,
    S_RR   = 21'h000040,
    S_RB   = 21'h000080,
    S_RP   = 21'h000100,
    S_PMS  = 21'h000200,
    S_PM   = 21'h000400,
    S_SS   = 21'h000800,
    S_FGO  = 21'h001000,
    S_WSQ  = 21'h002000,
    S_LGO  = 21'h004000,
    S_WDIV = 21'h008000,
    S_TERM = 21'h010000,
    S_MLW  = 21'h020000,
    S_MOW  = 21'h040000,
    S_ACC  = 21'h080000,
    S_OUT  = 21'h100000
  } elo_state_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TARGET  = 2'd0;
  localparam logic [1:0] REG_LWEIGHT = 2'd1;
  localparam logic [1:0] REG_OWEIGHT = 2'd2;

  // reset values of the registers
  localparam logic [22:0] TARGET_RST  = 23'd256;
  localparam logic [15:0] WEIGHT_RST  = 16'd256;

  // saturation limits and special values
  localparam logic [31:0] TERM_MAX    = 32'hFFFF_FFFF;
  localparam logic [55:0] TOTAL_MAX   = 56'hFF_FFFF_FFFF_FFFF;
  localparam logic [16:0] OCTI_ONE    = 17'h10000;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
  } elo_unit_st_t;

endpackage

// ===== rtl/elo_sqrt.sv =====
// bit-serial integer square root, one result bit per cycle
module elo_sqrt import elo_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start_i,
  input  logic [62:0]  n_i,
  output elo_unit_st_t st_o,
  output logic [31:0]  root_o
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [62:0] n_r;
  logic [62:0] res_r;
  logic [62:0] bit_r;
  logic [63:0] trial;
  logic        ge;

  // trial subtraction of the current root bit
  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign ge    = {1'b0, n_r} >= trial;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      n_r   <= n_i;
      res_r <= '0;
      bit_r <= {1'b1, 62'd0};
    end else if (busy_r) begin
      if (ge) begin
        n_r   <= n_r - trial[62:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign st_o.busy = busy_r;
  assign root_o    = res_r[31:0];

endmodule

// ===== rtl/elo_div.sv =====
// restoring serial divider, one quotient bit per cycle
module elo_div import elo_pkg::*; #(
  parameter int XW = 16,
  parameter int DW = 62
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  input  logic [DW-1:0] r0_i,
  input  logic [DW-1:0] d_i,
  output elo_unit_st_t  st_o,
  output logic [XW-1:0] q_o
);

  localparam int CW = $clog2(XW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [XW-1:0] x_r;
  logic [DW-1:0] r_r;
  logic [DW-1:0] d_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // shift in the next dividend bit and compare
  assign trial = {r_r, x_r[XW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(XW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath: dividend bits leave at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r <= x_i;
      r_r <= r0_i;
      d_r <= d_i;
    end else if (busy_r) begin
      r_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      x_r <= {x_r[XW-2:0], ge};
    end
  end

  assign st_o.busy = busy_r;
  assign q_o       = x_r;

endmodule

// ===== rtl/edge_length_octilinearity_criterion_top.sv =====
// top level of the edge length and octilinearity criterion accumulator
//
// Input channel in_*: one graph edge per request, two endpoints in signed
// Q16.8 plus first_edge and last_edge flags. Output channel out_*: one
// result per edge with the length term (Q16.16, saturating), the
// octilinearity term (Q1.16), the running weighted total (Q40.16,
// saturating) and total_done, a copy of last_edge.
// Configuration by an APB-style port: target_length at 0x0, length_weight
// at 0x4, octi_weight at 0x8; pready is always high, reads return values.
// The square root of the length (32 steps) followed by the length
// division (41 steps) take most of the time from accept to out_valid;
// the octilinearity division runs alongside the square root.
// One edge is in flight at a time: a new edge is accepted only when the
// sequencer is idle again. in_ready is high whenever the sequencer is idle,
// also while a finished result still waits in the output register.
// A stalled receiver holds the sequencer at its final step until the
// output register frees; no result is lost. Reset (rst_n, synchronous)
// clears the total and sets target 256 and both weights 256 (1.0).
module edge_length_octilinearity_criterion_top import elo_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // edge requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [23:0]  in_start_x,
  input  logic signed [23:0]  in_start_y,
  input  logic signed [23:0]  in_end_x,
  input  logic signed [23:0]  in_end_y,
  input  logic                in_first_edge,
  input  logic                in_last_edge,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_length_term,
  output logic [16:0]         out_octi_term,
  output logic [55:0]         out_running_total,
  output logic                out_total_done,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

`include "edge_length_octilinearity_criterion_top_defines.svh"

  elo_state_t   state_r, state_nxt;

  logic [22:0]  target_r;
  logic [15:0]  lweight_r;
  logic [15:0]  oweight_r;
  logic [55:0]  acc_r;

  logic [24:0]  dx_r, dy_r;
  logic         first_r, last_r, zero_r;
  logic [23:0]  a_r, b_r, ra_r, rb_r;
  logic [47:0]  sqa_r;
  logic [29:0]  raa_r, rbb_r;
  logic [30:0]  p_r, s_r;
  logic [29:0]  m_r;
  logic [61:0]  num_r;
  logic         full_r;
  logic [31:0]  lterm_r;
  logic [16:0]  oterm_r;
  logic [47:0]  wsum_r;
  logic [40:0]  add_r;
  logic [63:0]  prod_r;
  logic [31:0]  op_a, op_b;

  logic         out_valid_r;
  logic [31:0]  out_lterm_r;
  logic [16:0]  out_oterm_r;
  logic [55:0]  out_total_r;
  logic         out_done_r;

  logic         accept, cfg_wr, out_free;
  logic [22:0]  t_eff;
  logic [29:0]  tt;
  logic [31:0]  root;
  logic [31:0]  diff;
  logic [48:0]  s_full;
  logic [40:0]  lq;
  logic [15:0]  fq;
  logic [48:0]  wtot;
  logic [55:0]  base;
  logic [56:0]  tot;
  elo_unit_st_t sq_st, fd_st, ld_st;
  logic         sq_go, fd_go, ld_go;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= TARGET_RST;
      lweight_r <= WEIGHT_RST;
      oweight_r <= WEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TARGET:  target_r  <= pwdata[22:0];
        REG_LWEIGHT: lweight_r <= pwdata[15:0];
        REG_OWEIGHT: oweight_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_TARGET:  prdata = {9'd0, target_r};
      REG_LWEIGHT: prdata = {16'd0, lweight_r};
      REG_OWEIGHT: prdata = {16'd0, oweight_r};
      default:     prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_ABS;
      S_ABS:  state_nxt = S_SQA;
      S_SQA:  state_nxt = S_SQB;
      S_SQB:  state_nxt = S_ROOT;
      S_ROOT: state_nxt = S_NORM;
      S_NORM: if ((ra_r[23:15] | rb_r[23:15]) == 9'd0) state_nxt = S_RR;
      S_RR:   state_nxt = S_RB;
      S_RB:   state_nxt = S_RP;
      S_RP:   state_nxt = S_PMS;
      S_PMS:  state_nxt = S_PM;
      S_PM:   state_nxt = S_SS;
      S_SS:   state_nxt = S_FGO;
      S_FGO:  state_nxt = S_WSQ;
      S_WSQ:  if (!sq_st.busy) state_nxt = S_LGO;
      S_LGO:  state_nxt = S_WDIV;
      S_WDIV: if (!ld_st.busy && !fd_st.busy) state_nxt = S_TERM;
      S_TERM: state_nxt = S_MLW;
      S_MLW:  state_nxt = S_MOW;
      S_MOW:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // shared multiplier, operands chosen by step, product registered
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_SQA:  begin op_a = {8'd0, a_r};          op_b = {8'd0, a_r};          end
      S_SQB:  begin op_a = {8'd0, b_r};          op_b = {8'd0, b_r};          end
      S_RR:   begin op_a = {17'd0, ra_r[14:0]};  op_b = {17'd0, ra_r[14:0]};  end
      S_RB:   begin op_a = {17'd0, rb_r[14:0]};  op_b = {17'd0, rb_r[14:0]};  end
      S_RP:   begin op_a = {17'd0, ra_r[14:0]};  op_b = {17'd0, rb_r[14:0]};  end
      S_PM:   begin op_a = {1'b0, p_r};          op_b = {2'd0, m_r};          end
      S_SS:   begin op_a = {1'b0, s_r};          op_b = {1'b0, s_r};          end
      S_MLW:  begin op_a = lterm_r;              op_b = {16'd0, lweight_r};   end
      S_MOW:  begin op_a = {15'd0, oterm_r};     op_b = {16'd0, oweight_r};   end
      default: begin op_a = '0;                  op_b = '0;                   end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {32'd0, op_a} * {32'd0, op_b};
  end

  // length path values
  assign s_full = {1'b0, sqa_r} + {1'b0, prod_r[47:0]};
  assign t_eff  = (target_r == 23'd0) ? 23'd1 : target_r;
  assign tt     = {t_eff, 7'd0};
  assign diff   = (root >= {2'd0, tt}) ? root - {2'd0, tt} : {2'd0, tt} - root;

  assign sq_go = (state_r == S_ROOT);
  assign fd_go = (state_r == S_FGO);
  assign ld_go = (state_r == S_LGO);

  // per-edge datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        dx_r    <= {in_end_x[23], in_end_x} - {in_start_x[23], in_start_x};
        dy_r    <= {in_end_y[23], in_end_y} - {in_start_y[23], in_start_y};
        first_r <= in_first_edge;
        last_r  <= in_last_edge;
      end
      S_ABS: begin
        a_r    <= dx_r[24] ? 24'(~dx_r + 25'd1) : dx_r[23:0];
        b_r    <= dy_r[24] ? 24'(~dy_r + 25'd1) : dy_r[23:0];
        ra_r   <= dx_r[24] ? 24'(~dx_r + 25'd1) : dx_r[23:0];
        rb_r   <= dy_r[24] ? 24'(~dy_r + 25'd1) : dy_r[23:0];
        zero_r <= (dx_r == 25'd0) && (dy_r == 25'd0);
      end
      S_SQB:  sqa_r <= prod_r[47:0];
      S_NORM: begin
        if ((ra_r[23:15] | rb_r[23:15]) != 9'd0) begin
          ra_r <= ra_r >> 1;
          rb_r <= rb_r >> 1;
        end
      end
      S_RB:   raa_r <= prod_r[29:0];
      S_RP:   rbb_r <= prod_r[29:0];
      S_PMS: begin
        p_r <= {prod_r[29:0], 1'b0};
        m_r <= (raa_r >= rbb_r) ? raa_r - rbb_r : rbb_r - raa_r;
        s_r <= {1'b0, raa_r} + {1'b0, rbb_r};
      end
      S_SS:   num_r  <= {prod_r[60:0], 1'b0};
      S_FGO:  full_r <= (num_r == prod_r[61:0]);
      S_TERM: begin
        lterm_r <= zero_r ? 32'd0 : ((lq[40:32] != 9'd0) ? TERM_MAX : lq[31:0]);
        oterm_r <= zero_r ? 17'd0 : (full_r ? OCTI_ONE : {1'b0, fq});
      end
      S_MOW:  wsum_r <= prod_r[47:0];
      S_ACC:  add_r  <= wtot[48:8];
      default: begin
      end
    endcase
  end

  assign wtot = {1'b0, wsum_r} + {16'd0, prod_r[32:0]};

  // serial arithmetic units
  elo_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (sq_go),
    .n_i     ({s_full, 14'd0}),
    .st_o    (sq_st),
    .root_o  (root)
  );

  elo_div #(.XW(16), .DW(62)) u_fdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (fd_go),
    .x_i     (16'd0),
    .r0_i    (num_r),
    .d_i     (prod_r[61:0]),
    .st_o    (fd_st),
    .q_o     (fq)
  );

  elo_div #(.XW(41), .DW(23)) u_ldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (ld_go),
    .x_i     ({diff, 9'd0}),
    .r0_i    (23'd0),
    .d_i     (t_eff),
    .st_o    (ld_st),
    .q_o     (lq)
  );

  // saturating running total
  assign base = first_r ? 56'd0 : acc_r;
  assign tot  = {1'b0, base} + {16'd0, add_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      acc_r       <= tot[56] ? TOTAL_MAX : tot[55:0];
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_lterm_r <= lterm_r;
      out_oterm_r <= oterm_r;
      out_total_r <= tot[56] ? TOTAL_MAX : tot[55:0];
      out_done_r  <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_length_term   = out_lterm_r;
  assign out_octi_term     = out_oterm_r;
  assign out_running_total = out_total_r;
  assign out_total_done    = out_done_r;

  // checks
  `ELO_ASSERT_NEXT(a_busy_after_req, accept, !in_ready, "request accepted but still ready")
  `ELO_ASSERT_NOW(a_octi_range, out_valid, out_octi_term <= OCTI_ONE, "octi term out of range")
  `ELO_ASSERT_NOW(a_result_src, $rose(out_valid), $past(state_r == S_OUT), "result without final step")

endmodule
